// ===== src/bsfc_pkg.sv =====
// Package: shared types, constants and the unstuffing helper for the frame checker.
`timescale 1ns / 1ps
`default_nettype none

package bsfc_pkg;

    localparam int PATTERN_BITS_DEFAULT = 16;
    localparam int COUNT_BITS_DEFAULT   = 32;
    localparam int RES_FIFO_DEPTH       = 4;

    localparam int START_PATTERN_RESET = 126;
    localparam int START_LEN_RESET     = 8;
    localparam int END_PATTERN_RESET   = 126;
    localparam int END_LEN_RESET       = 8;
    localparam int STUFF_RUN_RESET     = 5;

    localparam int CFG_INDEX_BITS = 3;
    localparam int LEN_BITS       = 5;
    localparam int RUN_BITS       = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_START_PATTERN = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_LEN     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_END_PATTERN   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_END_LEN       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STUFF_RUN     = 3'd4;

    localparam logic [2:0] VERDICT_COMPLETE = 3'd0;
    localparam logic [2:0] VERDICT_NO_START = 3'd1;
    localparam logic [2:0] VERDICT_NO_END   = 3'd2;
    localparam logic [2:0] VERDICT_EMPTY    = 3'd3;
    localparam logic [2:0] VERDICT_MISMATCH = 3'd4;

    localparam logic RESULT_PAYLOAD = 1'b0;
    localparam logic RESULT_VERDICT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic       pbit;
        logic [2:0] verdict;
        logic       err;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } res_push_t;

    typedef struct packed {
        logic                keep;
        logic                drop;
        logic [RUN_BITS-1:0] ones;
        logic                err;
    } unstuff_t;

    // Pattern length clamped to 1..pb
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] v,
                                                    input int pb);
        logic [LEN_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = LEN_BITS'(1);
        end else if ({1'b0, v} > (LEN_BITS+1)'(pb)) begin
            r = LEN_BITS'(pb);
        end
        return r;
    endfunction

    function automatic unstuff_t unstuff(input logic b, input logic drop,
                                         input logic [RUN_BITS-1:0] ones,
                                         input logic [RUN_BITS-1:0] run);
        unstuff_t r;
        r.keep = 1'b1;
        r.drop = drop;
        r.ones = ones;
        r.err  = 1'b0;
        if (drop) begin
            r.keep = 1'b0;
            r.drop = 1'b0;
            r.err  = b;
        end else if (b) begin
            if (ones != '1) begin
                r.ones = ones + RUN_BITS'(1);
            end
            if (run != '0 && r.ones == run) begin
                r.drop = 1'b1;
                r.ones = '0;
            end
        end else begin
            r.ones = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/bsfc_res_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transaction.
`timescale 1ns / 1ps
`default_nettype none

module bsfc_res_fifo
    import bsfc_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire res_push_t push,
    output logic           room,
    output logic           m_valid,
    input  wire logic      m_ready,
    output res_t           m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    res_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign room    = (count_reg <= CW'(DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + AW'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire

// ===== src/bit_stuffed_frame_checker_core.sv =====
// Top level: bit-stuffed frame checker (start hunt, header length, payload unstuffing).
`timescale 1ns / 1ps
`default_nettype none

// One received bit is taken per cycle per s_axis transaction. The bit is decoded in the
// cycle it is accepted and its results (an unstuffed payload bit and/or, on tlast, the
// frame verdict) appear on m_axis from the next cycle through a four-entry result queue.
// s_axis_tready drops only when fewer than two queue slots are free, i.e. when m_axis
// is held off; with m_axis always ready the block sustains one bit per cycle. Result
// tuser is 0 for a payload bit, 1 for a verdict (which also carries tlast). The
// configuration channel is always ready; writes should be made while no frame is open.

module bit_stuffed_frame_checker_core
    import bsfc_pkg::*;
#(
    parameter int PATTERN_BITS = PATTERN_BITS_DEFAULT,
    parameter int COUNT_BITS   = COUNT_BITS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // s_axis_tdata: [0] in_bit
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,
    input  wire logic       s_axis_tlast,
    // m_axis_tdata: [0] payload_bit, [3:1] verdict, [4] stuff_error
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    // m_axis_tuser: [0] result_kind
    output logic            m_axis_tuser,
    output logic            m_axis_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [((PATTERN_BITS > LEN_BITS) ? PATTERN_BITS : LEN_BITS)-1:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_PAY  = 3'b100
    } phase_t;

    logic [PATTERN_BITS-1:0] start_pattern_reg, end_pattern_reg;
    logic [LEN_BITS-1:0]     start_len_reg, end_len_reg;
    logic [RUN_BITS-1:0]     stuff_run_reg;

    phase_t                  phase_reg, phase_next;
    logic [PATTERN_BITS-1:0] start_window_reg, start_window_next;
    logic [PATTERN_BITS-1:0] end_window_reg, end_window_next;
    logic [LEN_BITS-1:0]     bits_reg, bits_next;
    logic [COUNT_BITS-1:0]   length_reg, length_next;
    logic                    has_bits_reg, has_bits_next;
    logic [RUN_BITS-1:0]     ones_reg, ones_next;
    logic                    drop_reg, drop_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    error_reg, error_next;

    logic      accept;
    logic      room;
    res_push_t push;
    res_t      res_out;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = room;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pattern_reg <= PATTERN_BITS'(START_PATTERN_RESET);
            start_len_reg     <= LEN_BITS'(START_LEN_RESET);
            end_pattern_reg   <= PATTERN_BITS'(END_PATTERN_RESET);
            end_len_reg       <= LEN_BITS'(END_LEN_RESET);
            stuff_run_reg     <= RUN_BITS'(STUFF_RUN_RESET);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_START_PATTERN: start_pattern_reg <= cfg_data[PATTERN_BITS-1:0];
                REG_START_LEN:     start_len_reg     <= cfg_data[LEN_BITS-1:0];
                REG_END_PATTERN:   end_pattern_reg   <= cfg_data[PATTERN_BITS-1:0];
                REG_END_LEN:       end_len_reg       <= cfg_data[LEN_BITS-1:0];
                REG_STUFF_RUN:     stuff_run_reg     <= cfg_data[RUN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [LEN_BITS-1:0]     sl;
        logic [LEN_BITS-1:0]     el;
        logic [PATTERN_BITS-1:0] smask;
        logic [PATTERN_BITS-1:0] emask;
        logic [PATTERN_BITS-1:0] ew_shift;
        logic                    b;
        logic                    old;
        unstuff_t                us;
        res_t                    vres;
        logic [2:0]              vcode;

        sl       = eff_len(start_len_reg, PATTERN_BITS);
        el       = eff_len(end_len_reg, PATTERN_BITS);
        smask    = ~({PATTERN_BITS{1'b1}} << sl);
        emask    = ~({PATTERN_BITS{1'b1}} << el);
        ew_shift = end_window_reg >> (el - LEN_BITS'(1));
        b        = s_axis_tdata[0];
        old      = ew_shift[0];
        us       = '0;
        vres     = '0;
        vcode    = VERDICT_COMPLETE;

        phase_next        = phase_reg;
        start_window_next = start_window_reg;
        end_window_next   = end_window_reg;
        bits_next         = bits_reg;
        length_next       = length_reg;
        has_bits_next     = has_bits_reg;
        ones_next         = ones_reg;
        drop_next         = drop_reg;
        count_next        = count_reg;
        error_next        = error_reg;
        push              = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    start_window_next = {start_window_reg[PATTERN_BITS-2:0], b};
                    if (bits_reg < sl) begin
                        bits_next = bits_reg + LEN_BITS'(1);
                    end
                    if (bits_next >= sl &&
                        (start_window_next & smask) == (start_pattern_reg & smask)) begin
                        phase_next      = PH_LEN;
                        end_window_next = '0;
                        bits_next       = '0;
                        length_next     = '0;
                        has_bits_next   = 1'b0;
                        ones_next       = '0;
                        drop_next       = 1'b0;
                        count_next      = '0;
                        error_next      = 1'b0;
                    end
                end
                PH_LEN: begin
                    if (bits_reg >= el) begin
                        has_bits_next = 1'b1;
                        us            = unstuff(old, drop_reg, ones_reg, stuff_run_reg);
                        drop_next     = us.drop;
                        ones_next     = us.ones;
                        error_next    = error_reg | us.err;
                        if (us.keep) begin
                            if (length_reg[COUNT_BITS-1]) begin
                                length_next = '1;
                            end else begin
                                length_next = {length_reg[COUNT_BITS-2:0], old};
                            end
                        end
                    end
                    end_window_next = {end_window_reg[PATTERN_BITS-2:0], b};
                    if (bits_reg < el) begin
                        bits_next = bits_reg + LEN_BITS'(1);
                    end
                    if (bits_next >= el &&
                        (end_window_next & emask) == (end_pattern_reg & emask)) begin
                        phase_next = PH_PAY;
                        ones_next  = '0;
                        drop_next  = 1'b0;
                        count_next = '0;
                    end
                end
                PH_PAY: begin
                    if (count_reg != '1) begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                    us         = unstuff(b, drop_reg, ones_reg, stuff_run_reg);
                    drop_next  = us.drop;
                    ones_next  = us.ones;
                    error_next = error_reg | us.err;
                    if (us.keep) begin
                        push.cnt         = 2'd1;
                        push.first.kind  = RESULT_PAYLOAD;
                        push.first.pbit  = b;
                        push.first.err   = error_next;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase

            if (s_axis_tlast) begin
                priority if (phase_next == PH_HUNT) begin
                    vcode = VERDICT_NO_START;
                end else if (phase_next == PH_LEN) begin
                    vcode = VERDICT_NO_END;
                end else if (!has_bits_next) begin
                    vcode = VERDICT_EMPTY;
                end else if (length_next == '1 || length_next != count_next) begin
                    vcode = VERDICT_MISMATCH;
                end else begin
                    vcode = VERDICT_COMPLETE;
                end
                vres.kind    = RESULT_VERDICT;
                vres.verdict = vcode;
                vres.err     = error_next;
                vres.last    = 1'b1;
                if (push.cnt == 2'd0) begin
                    push.first = vres;
                    push.cnt   = 2'd1;
                end else begin
                    push.second = vres;
                    push.cnt    = 2'd2;
                end

                phase_next        = PH_HUNT;
                start_window_next = '0;
                end_window_next   = '0;
                bits_next         = '0;
                length_next       = '0;
                has_bits_next     = 1'b0;
                ones_next         = '0;
                drop_next         = 1'b0;
                count_next        = '0;
                error_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            start_window_reg <= '0;
            end_window_reg   <= '0;
            bits_reg         <= '0;
            length_reg       <= '0;
            has_bits_reg     <= 1'b0;
            ones_reg         <= '0;
            drop_reg         <= 1'b0;
            count_reg        <= '0;
            error_reg        <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            start_window_reg <= start_window_next;
            end_window_reg   <= end_window_next;
            bits_reg         <= bits_next;
            length_reg       <= length_next;
            has_bits_reg     <= has_bits_next;
            ones_reg         <= ones_next;
            drop_reg         <= drop_next;
            count_reg        <= count_next;
            error_reg        <= error_next;
        end
    end

    bsfc_res_fifo #(
        .DEPTH (RES_FIFO_DEPTH)
    ) u_res_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (res_out)
    );

    assign m_axis_tdata = {3'b000, res_out.err, res_out.verdict, res_out.pbit};
    assign m_axis_tuser = res_out.kind;
    assign m_axis_tlast = res_out.last;

endmodule

`default_nettype wire

// ===== src/bsfc_checker.sv =====
// Port checker for the frame checker core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bsfc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a held result transaction must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // payload results carry no verdict and never close a frame
    a_payload_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |->
            !m_axis_tlast && m_axis_tdata[3:1] == 3'd0 && m_axis_tdata[7:5] == 3'd0)
        else $error("malformed payload result");

    // verdicts close the frame and use a defined code
    a_verdict_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && !m_axis_tdata[0] && !(m_axis_tdata[3] && m_axis_tdata[2])
            && !(m_axis_tdata[3] && m_axis_tdata[1]) && m_axis_tdata[7:5] == 3'd0)
        else $error("malformed verdict result");

    // queue comes out of reset empty and able to take input
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("outputs not cleared by reset");

endmodule

bind bit_stuffed_frame_checker_core bsfc_checker u_bsfc_checker (.*);

`default_nettype wire

// ===== tb/tb_bit_stuffed_frame_checker_core.sv =====
// Testbench for the bit-stuffed frame checker: message bits checked against a local decoder.
`timescale 1ns / 1ps

module tb_bit_stuffed_frame_checker_core;
    import bsfc_pkg::*;

    localparam int CFG_DATA_BITS = (PATTERN_BITS_DEFAULT > LEN_BITS) ? PATTERN_BITS_DEFAULT
                                                                     : LEN_BITS;
    localparam logic [31:0] COUNT_MAX = '1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LOW  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HIGH = 3'd7;
    localparam int RANDOM_BITS    = 700;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum logic [1:0] {HUNT_START, READ_LENGTH, IN_PAYLOAD} frame_phase_t;

    typedef struct {
        bit value;
        bit eom;
    } msg_bit_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;   // [0] in_bit
    logic                      s_axis_tlast  = 1'b0; // msg_end
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;         // [0] payload_bit, [3:1] verdict, [4] stuff_error
    logic                      m_axis_tuser;         // [0] result_kind
    logic                      m_axis_tlast;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;

    bit_stuffed_frame_checker_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 aclk = ~aclk;

    // decoder copy: configuration
    logic [15:0] sof_pattern, eoh_pattern;
    logic [4:0]  sof_len, eoh_len;
    logic [3:0]  stuff_limit;
    // decoder copy: frame state
    frame_phase_t fphase;
    logic [15:0]  hunt_win, hdr_win;
    int           win_fill;
    logic [31:0]  hdr_length, payload_seen;
    bit           hdr_length_seen, skip_next, stuff_err;
    logic [3:0]   ones_count;

    msg_bit_t pending_bits[$];
    res_t     decoded_results[$];
    bit       bit_in_flight = 1'b0;
    int       items_queued  = 0;
    int       mismatches    = 0;
    int       hold_token    = 0;
    logic [1:0] rx_style    = 2'd0;

    function automatic int clamp_len(input logic [4:0] v);
        if (v == 5'd0) return 1;
        if (v > 5'd16) return 16;
        return int'(v);
    endfunction

    function automatic logic [15:0] len_mask(input int n);
        logic [16:0] full;
        full = (17'd1 << n) - 17'd1;
        return full[15:0];
    endfunction

    task automatic clear_frame();
        fphase          = HUNT_START;
        hunt_win        = '0;
        hdr_win         = '0;
        win_fill        = 0;
        hdr_length      = '0;
        hdr_length_seen = 1'b0;
        ones_count      = '0;
        skip_next       = 1'b0;
        payload_seen    = '0;
        stuff_err       = 1'b0;
    endtask

    task automatic reset_decoder();
        sof_pattern = 16'(START_PATTERN_RESET);
        sof_len     = 5'(START_LEN_RESET);
        eoh_pattern = 16'(END_PATTERN_RESET);
        eoh_len     = 5'(END_LEN_RESET);
        stuff_limit = 4'(STUFF_RUN_RESET);
        clear_frame();
    endtask

    // returns 1 when the bit survives unstuffing
    function automatic bit strip_stuffed(input bit b);
        if (skip_next) begin
            skip_next = 1'b0;
            if (b) stuff_err = 1'b1;
            return 1'b0;
        end
        if (b) begin
            if (ones_count != 4'hF) ones_count++;
            if (stuff_limit != 4'd0 && ones_count == stuff_limit) begin
                skip_next  = 1'b1;
                ones_count = '0;
            end
        end else begin
            ones_count = '0;
        end
        return 1'b1;
    endfunction

    task automatic add_result(input logic kind, input logic pbit, input logic [2:0] verd,
                              input logic last);
        res_t r;
        r.kind    = kind;
        r.pbit    = pbit;
        r.verdict = verd;
        r.err     = stuff_err;
        r.last    = last;
        decoded_results.insert(decoded_results.size(), r);
    endtask

    task automatic decode_bit(input bit b, input bit eom);
        int          n;
        logic [15:0] m;
        bit          old;
        logic [2:0]  v;
        if (fphase == HUNT_START) begin
            n        = clamp_len(sof_len);
            m        = len_mask(n);
            hunt_win = {hunt_win[14:0], b};
            if (win_fill < n) win_fill++;
            if (win_fill >= n && (hunt_win & m) == (sof_pattern & m)) begin
                clear_frame();
                fphase = READ_LENGTH;
            end
        end else if (fphase == READ_LENGTH) begin
            n = clamp_len(eoh_len);
            m = len_mask(n);
            if (win_fill >= n) begin
                old             = hdr_win[n-1];
                hdr_length_seen = 1'b1;
                if (strip_stuffed(old)) begin
                    if (hdr_length > (COUNT_MAX >> 1)) hdr_length = COUNT_MAX;
                    else hdr_length = {hdr_length[30:0], old};
                end
            end
            hdr_win = {hdr_win[14:0], b};
            if (win_fill < n) win_fill++;
            if (win_fill >= n && (hdr_win & m) == (eoh_pattern & m)) begin
                fphase       = IN_PAYLOAD;
                ones_count   = '0;
                skip_next    = 1'b0;
                payload_seen = '0;
            end
        end else begin
            if (payload_seen != COUNT_MAX) payload_seen++;
            if (strip_stuffed(b)) add_result(RESULT_PAYLOAD, b, VERDICT_COMPLETE, 1'b0);
        end
        if (eom) begin
            if (fphase == HUNT_START) v = VERDICT_NO_START;
            else if (fphase == READ_LENGTH) v = VERDICT_NO_END;
            else if (!hdr_length_seen) v = VERDICT_EMPTY;
            else if (hdr_length == COUNT_MAX || hdr_length != payload_seen) v = VERDICT_MISMATCH;
            else v = VERDICT_COMPLETE;
            add_result(RESULT_VERDICT, 1'b0, v, 1'b1);
            clear_frame();
        end
    endtask

    // ---------------- driver ----------------
    int       burst_left = 0;
    int       gap_left   = 0;
    msg_bit_t nxt_bit;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_bit(s_axis_tdata[0], s_axis_tlast);
                bit_in_flight = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bits.size() > 0) begin
                    nxt_bit       = pending_bits.pop_front();
                    s_axis_tdata  <= {7'd0, nxt_bit.value};
                    s_axis_tlast  <= nxt_bit.eom;
                    s_axis_tvalid <= 1'b1;
                    bit_in_flight = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int   rx_count  = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    res_t want;

    task automatic check_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (decoded_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual tuser=%0b tdata=%h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = decoded_results.pop_front();
                check_field("result_kind", want.kind, m_axis_tuser);
                check_field("payload_bit", want.pbit, m_axis_tdata[0]);
                check_field("verdict", want.verdict, m_axis_tdata[3:1]);
                check_field("stuff_error", want.err, m_axis_tdata[4]);
                check_field("is_last", want.last, m_axis_tlast);
            end
        end
        rx_count++;
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_style)
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= !((rx_count % 7) == 3 || (rx_count % 23) >= 19);
                2'd2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("FAIL bit_stuffed_frame_checker_core");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic cfg_put(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_START_PATTERN: sof_pattern = value;
            REG_START_LEN:     sof_len     = value[4:0];
            REG_END_PATTERN:   eoh_pattern = value;
            REG_END_LEN:       eoh_len     = value[4:0];
            REG_STUFF_RUN:     stuff_limit = value[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] sp, input logic [4:0] sl, input logic [15:0] ep,
                              input logic [4:0] el, input logic [3:0] sr);
        cfg_put(REG_START_PATTERN, sp);
        cfg_put(REG_START_LEN, {11'd0, sl});
        cfg_put(REG_END_PATTERN, ep);
        cfg_put(REG_END_LEN, {11'd0, el});
        cfg_put(REG_STUFF_RUN, {12'd0, sr});
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_bits.size() != 0 || bit_in_flight || decoded_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_bit(input bit b, input bit eom);
        msg_bit_t mb;
        mb.value = b;
        mb.eom   = eom;
        pending_bits.insert(pending_bits.size(), mb);
        items_queued++;
    endtask

    task automatic queue_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            queue_bit(1'($urandom_range(0, 1)), (i == n - 1) || ($urandom_range(0, 15) == 0));
    endtask

    task automatic stuff_bits(input bit src[$], output bit dst[$], output int marks[$]);
        int ones;
        int i;
        dst   = {};
        marks = {};
        ones  = 0;
        for (i = 0; i < src.size(); i++) begin
            dst.insert(dst.size(), src[i]);
            if (src[i]) begin
                ones++;
                if (stuff_limit != 4'd0 && ones == int'(stuff_limit)) begin
                    marks.insert(marks.size(), dst.size());
                    dst.insert(dst.size(), 1'b0);
                    ones = 0;
                end
            end else begin
                ones = 0;
            end
        end
    endtask

    // start pattern, stuffed length, end pattern, stuffed payload; msg_end on the last bit
    task automatic build_frame(input int n_data, input int len_delta, input bit empty_hdr,
                               input bit oversize, input bit bad_stuff, input bit cut_short);
        bit data[$], pay_w[$], hdr_d[$], hdr_w[$], frame[$];
        int marks[$], hmarks[$];
        int sl, el, n, w, i, keep;
        bit dense;
        sl    = clamp_len(sof_len);
        el    = clamp_len(eoh_len);
        dense = bad_stuff || ($urandom_range(0, 1) == 1);
        for (i = 0; i < n_data; i++)
            data.insert(data.size(),
                        dense ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1)));
        stuff_bits(data, pay_w, marks);
        if (bad_stuff && marks.size() > 0) pay_w[marks[$urandom_range(0, marks.size() - 1)]] = 1'b1;
        n = pay_w.size() + len_delta;
        if (n < 0) n = 0;
        if (!empty_hdr) begin
            if (oversize) begin
                for (i = 0; i < 40; i++) hdr_d.insert(hdr_d.size(), 1'b1);
            end else begin
                w = 1;
                while ((n >> w) != 0) w++;
                w += $urandom_range(0, 2);
                for (i = w - 1; i >= 0; i--) hdr_d.insert(hdr_d.size(), bit'((n >> i) & 1));
            end
        end
        stuff_bits(hdr_d, hdr_w, hmarks);
        for (i = sl - 1; i >= 0; i--) frame.insert(frame.size(), sof_pattern[i]);
        foreach (hdr_w[k]) frame.insert(frame.size(), hdr_w[k]);
        for (i = el - 1; i >= 0; i--) frame.insert(frame.size(), eoh_pattern[i]);
        foreach (pay_w[k]) frame.insert(frame.size(), pay_w[k]);
        keep = frame.size();
        if (cut_short && keep > 1) keep = $urandom_range(1, keep - 1);
        for (i = 0; i < keep; i++) queue_bit(frame[i], i == keep - 1);
    endtask

    task automatic pick_config();
        int          sel, r1, r2;
        logic [15:0] sp, ep;
        logic [4:0]  sl, el;
        logic [3:0]  sr;
        sel = $urandom_range(0, 5);
        case (sel)
            0: begin
                r1 = $urandom_range(1, 13);
                r2 = $urandom_range(r1, 13);
                sp = 16'(((1 << (r1 + 1)) - 1) << 1);
                sl = 5'(r1 + 3);
                ep = 16'(((1 << (r2 + 1)) - 1) << 1);
                el = 5'(r2 + 3);
                sr = 4'(r1);
            end
            1: begin
                sp = 16'h007E; sl = 5'd8; ep = 16'h007E; el = 5'd8; sr = 4'd5;
            end
            2: begin
                sp = 16'hFFFF; sl = 5'd16; ep = 16'hFFFF; el = 5'd16; sr = 4'd15;
            end
            3: begin
                sp = 16'($urandom); sl = 5'($urandom_range(0, 31));
                ep = 16'($urandom); el = 5'($urandom_range(0, 31));
                sr = 4'($urandom_range(0, 15));
            end
            4: begin
                sp = {8'($urandom), 8'h7E}; sl = 5'd8;
                ep = {8'($urandom), 8'h7E}; el = 5'd8;
                sr = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'd5;
            end
            default: begin
                sp = 16'($urandom); sl = 5'($urandom_range(0, 1));
                ep = 16'($urandom);
                el = ($urandom_range(0, 1) == 1) ? 5'd0 : 5'($urandom_range(17, 31));
                sr = 4'($urandom_range(0, 15));
            end
        endcase
        set_config(sp, sl, ep, el, sr);
        if ($urandom_range(0, 2) == 0)
            cfg_put(3'($urandom_range(REG_SPARE_LOW, REG_SPARE_HIGH)), 16'($urandom));
    endtask

    initial begin
        int phase_no, phase_end, target, r;
        reset_decoder();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values of the registers
        build_frame(4, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // short patterns: 011 start, 110 end, stuffing after every one
        set_config(16'h0003, 5'd3, 16'h0006, 5'd3, 4'd1);
        queue_bit(1'b0, 1'b1);
        queue_bit(1'b1, 1'b1);
        queue_bit(1'b0, 1'b0);
        queue_bit(1'b1, 1'b0);
        queue_bit(1'b1, 1'b1);
        build_frame(0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
        build_frame(1, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        build_frame(2, 1, 1'b0, 1'b0, 1'b1, 1'b0);
        wait_drained();

        target   = items_queued + RANDOM_BITS;
        phase_no = 0;
        while (items_queued < target) begin
            pick_config();
            rx_style  <= 2'($urandom_range(0, 3));
            phase_end = items_queued + $urandom_range(60, 140);
            while (items_queued < phase_end) begin
                r = $urandom_range(0, 19);
                if (r < 2) begin
                    queue_noise($urandom_range(1, 12));
                end else begin
                    build_frame(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                            : $urandom_range(0, 12),
                                (r == 2) ? 1 : (r == 3) ? -1 : 0,
                                r == 4, r == 5, r == 6, r == 7);
                    if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 4));
                end
            end
            if (phase_no == 2 || phase_no == 5) hold_token <= hold_token + 1;
            phase_no++;
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("PASS bit_stuffed_frame_checker_core");
        end else begin
            $display("FAIL bit_stuffed_frame_checker_core");
        end
        $finish;
    end

endmodule
